// File: rtl/scaled_bitmap_glyph_rasterizer_unit_assert.svh
// Assertion macros for the glyph rasterizer.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef SCALED_BITMAP_GLYPH_RASTERIZER_UNIT_ASSERT_SVH
`define SCALED_BITMAP_GLYPH_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define SBGR_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define SBGR_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: rtl/sbgr_pkg.sv
// Shared types, constants and scaling tables for the glyph rasterizer.
// No dependencies.
package sbgr_pkg;

   localparam int CELL_COLS = 5;

   localparam logic [7:0] CODE_FIRST = 8'h20;
   localparam logic [7:0] CODE_LAST  = 8'h7E;
   localparam logic [7:0] CODE_SUBST = 8'h3F;

   // request modes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   localparam logic [2:0] FONT_BOLD = 3'd7;

   // register indexes of the configuration port
   localparam logic [2:0] REG_DISPLAY_WIDTH  = 3'd0;
   localparam logic [2:0] REG_DISPLAY_HEIGHT = 3'd1;
   localparam logic [2:0] REG_CLIP_LEFT      = 3'd2;
   localparam logic [2:0] REG_CLIP_TOP       = 3'd3;
   localparam logic [2:0] REG_CLIP_WIDTH     = 3'd4;
   localparam logic [2:0] REG_CLIP_HEIGHT    = 3'd5;

   typedef logic [3:0] dy_type;
   typedef logic [2:0] col_idx_type;

   // cell size per font select
   localparam logic [3:0] CELL_W [8] = '{4'd5, 4'd3, 4'd4, 4'd4, 4'd6, 4'd7, 4'd8, 4'd5};
   localparam logic [3:0] CELL_H [8] = '{4'd7, 4'd5, 4'd5, 4'd7, 4'd9, 4'd10, 4'd11, 4'd7};

   // source row for each destination row, rounded nearest mapping
   localparam logic [2:0] ROW_MAP [8][11] = '{
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd2, 3'd3, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd2, 3'd3, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd0, 3'd0},
      '{3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd0},
      '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6},
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0}
   };

   // source column for each destination column
   localparam logic [2:0] COL_MAP [8][8] = '{
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd2, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd1, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd1, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0, 3'd0},
      '{3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd0},
      '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4},
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0}
   };

   typedef struct packed {
      logic               mode;
      logic [7:0]         char_code;
      logic [2:0]         font_column;
      logic [6:0]         column_bits;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [2:0]         font_sel;
      logic               clip_enable;
      logic [15:0]        ink_color;
      logic               display_sel;
   } req_item_type;

   typedef struct packed {
      logic               out_display;
      logic [9:0]         row_y;
      logic signed [11:0] row_x;
      logic [7:0]         pixel_mask;
      logic [15:0]        out_color;
      logic               last_row;
   } rsp_item_type;

   typedef struct packed {
      logic        start;
      logic        store_wr;
      logic        rd_en;
      col_idx_type rd_col;
      logic        cap_en;
      col_idx_type cap_col;
      dy_type      dy;
      logic        pend_load;
      logic        pend_push;
      logic        pend_flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic row_hit;
      logic row_end;
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/sbgr_intf.sv
// Channel interfaces of the glyph rasterizer: request, row response, register write.
// No dependencies.
interface sbgr_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [7:0]         char_code;
   logic [2:0]         font_column;
   logic [6:0]         column_bits;
   logic signed [11:0] pos_x;
   logic signed [11:0] pos_y;
   logic [2:0]         font_sel;
   logic               clip_enable;
   logic [15:0]        ink_color;
   logic               display_sel;

   modport source (output valid, mode, char_code, font_column, column_bits, pos_x, pos_y,
                   font_sel, clip_enable, ink_color, display_sel, input ready);
   modport sink (input valid, mode, char_code, font_column, column_bits, pos_x, pos_y,
                 font_sel, clip_enable, ink_color, display_sel, output ready);
endinterface

interface sbgr_rsp_if;
   logic               valid;
   logic               ready;
   logic               out_display;
   logic [9:0]         row_y;
   logic signed [11:0] row_x;
   logic [7:0]         pixel_mask;
   logic [15:0]        out_color;
   logic               last_row;

   modport source (output valid, out_display, row_y, row_x, pixel_mask, out_color, last_row,
                   input ready);
   modport sink (input valid, out_display, row_y, row_x, pixel_mask, out_color, last_row,
                 output ready);
endinterface

interface sbgr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [11:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/scaled_bitmap_glyph_rasterizer_unit.sv
// Top level of the scaled 5x7 glyph rasterizer: controller plus datapath.
// Depends on sbgr_pkg, sbgr_intf.sv, sbgr_controller, sbgr_datapath and the assert header.
//
//   channel   dir  carries
//   req_chan  in   load-column or draw-character request
//   rsp_chan  out  one pixel-mask row per visible, non-empty glyph row
//   csr_chan  in   register index and write data, always ready
//
// A load request is written in the idle state. A draw runs intake, glyph
// column fetch from the single-read-port font store, a walk over the cell
// rows (5 to 11 rows) and a flush.
// Each hit row is held in the pending register so the final row can be flagged last.
// A stalled output holds the row walk only when a second hit row is ready.
// Synchronous reset restores the register defaults; the font store is not cleared.
`include "scaled_bitmap_glyph_rasterizer_unit_assert.svh"

module scaled_bitmap_glyph_rasterizer_unit #(
   parameter int GLYPH_COUNT = 95
) (
   input logic      clock,
   input logic      reset,
   sbgr_req_if.sink   req_chan,
   sbgr_rsp_if.source rsp_chan,
   sbgr_csr_if.sink   csr_chan
);
   import sbgr_pkg::*;

   req_item_type  req_item;
   rsp_item_type  rsp_item;
   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          ctl_ready;
   logic          dp_rsp_valid;

   assign req_item = '{
      mode:        req_chan.mode,
      char_code:   req_chan.char_code,
      font_column: req_chan.font_column,
      column_bits: req_chan.column_bits,
      pos_x:       req_chan.pos_x,
      pos_y:       req_chan.pos_y,
      font_sel:    req_chan.font_sel,
      clip_enable: req_chan.clip_enable,
      ink_color:   req_chan.ink_color,
      display_sel: req_chan.display_sel
   };

   assign req_chan.ready = ctl_ready;
   assign csr_chan.ready = 1'b1;

   sbgr_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_draw  (req_chan.mode),
      .req_ready (ctl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sbgr_datapath #(
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_wr    (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (dp_rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_chan.valid       = dp_rsp_valid;
   assign rsp_chan.out_display = rsp_item.out_display;
   assign rsp_chan.row_y       = rsp_item.row_y;
   assign rsp_chan.row_x       = rsp_item.row_x;
   assign rsp_chan.pixel_mask  = rsp_item.pixel_mask;
   assign rsp_chan.out_color   = rsp_item.out_color;
   assign rsp_chan.last_row    = rsp_item.last_row;

   `SBGR_ASSERT_NEXT(a_rsp_from_pend, !rsp_chan.valid && !cmd.pend_push && !cmd.pend_flush, !rsp_chan.valid, "response valid without a row push")
   `SBGR_ASSERT_SAME(a_push_not_idle, cmd.pend_push || cmd.pend_flush, !req_chan.ready, "row pushed while taking requests")
   `SBGR_ASSERT_NEXT(a_flush_last, cmd.pend_flush, rsp_chan.valid && rsp_chan.last_row, "flushed row not flagged last")

endmodule

// File: rtl/sbgr_datapath.sv
// Datapath: configuration registers, font store, glyph column registers,
// row mask logic, pending row and output register. Uses sbgr_pkg.
module sbgr_datapath #(
   parameter int GLYPH_COUNT = 95
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sbgr_pkg::req_item_type req_item,
   input  logic                  csr_wr,
   input  logic [2:0]            csr_index,
   input  logic [11:0]           csr_data,
   input  sbgr_pkg::ctl_cmd_type cmd,
   output sbgr_pkg::dp_status_type status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sbgr_pkg::rsp_item_type rsp_item
);
   import sbgr_pkg::*;

   localparam int STORE_DEPTH = GLYPH_COUNT * CELL_COLS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int LIN_W       = 11;

   // configuration
   logic [10:0]        disp_w_ff, disp_h_ff;
   logic signed [11:0] clip_left_ff, clip_top_ff;
   logic [11:0]        clip_w_ff, clip_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_w_ff    <= 11'd320;
         disp_h_ff    <= 11'd240;
         clip_left_ff <= '0;
         clip_top_ff  <= '0;
         clip_w_ff    <= '0;
         clip_h_ff    <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_DISPLAY_WIDTH:  disp_w_ff    <= csr_data[10:0];
            REG_DISPLAY_HEIGHT: disp_h_ff    <= csr_data[10:0];
            REG_CLIP_LEFT:      clip_left_ff <= csr_data;
            REG_CLIP_TOP:       clip_top_ff  <= csr_data;
            REG_CLIP_WIDTH:     clip_w_ff    <= csr_data;
            REG_CLIP_HEIGHT:    clip_h_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   logic [10:0] w_sat, h_sat;
   assign w_sat = (disp_w_ff > 11'd1024) ? 11'd1024 : disp_w_ff;
   assign h_sat = (disp_h_ff > 11'd1024) ? 11'd1024 : disp_h_ff;

   // draw code mapping
   logic [7:0] code_map;
   logic [6:0] gidx;
   logic       glyph_ok;
   assign code_map = (req_item.char_code < CODE_FIRST || req_item.char_code > CODE_LAST) ?
                     CODE_SUBST : req_item.char_code;
   assign gidx     = 7'(code_map - CODE_FIRST);
   assign glyph_ok = 9'(gidx) < 9'(GLYPH_COUNT);

   // item registers
   logic signed [11:0] x_ff, y_ff;
   logic [2:0]         fsel_ff;
   logic               clip_ff, dsel_ff, glyph_ok_ff;
   logic [15:0]        color_ff;
   logic [6:0]         gidx_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff        <= req_item.pos_x;
         y_ff        <= req_item.pos_y;
         fsel_ff     <= req_item.font_sel;
         clip_ff     <= req_item.clip_enable;
         dsel_ff     <= req_item.display_sel;
         color_ff    <= req_item.ink_color;
         gidx_ff     <= gidx;
         glyph_ok_ff <= glyph_ok;
      end
   end

   // font store
   logic [7:0]        lidx;
   logic              load_ok;
   logic [LIN_W-1:0]  wr_lin, rd_lin;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [6:0]        store_mem [STORE_DEPTH];
   logic [6:0]        rd_data_ff;

   assign lidx    = req_item.char_code - CODE_FIRST;
   assign load_ok = (req_item.char_code >= CODE_FIRST) && (9'(lidx) < 9'(GLYPH_COUNT)) &&
                    (req_item.font_column < 3'(CELL_COLS));
   assign wr_lin  = {1'b0, lidx, 2'b00} + LIN_W'(lidx) + LIN_W'(req_item.font_column);
   assign rd_lin  = {2'b00, gidx_ff, 2'b00} + LIN_W'(gidx_ff) + LIN_W'(cmd.rd_col);
   assign wr_addr = ADDR_W'(wr_lin);
   assign rd_addr = ADDR_W'(rd_lin);

   always_ff @(posedge clock) begin
      if (cmd.store_wr && load_ok) begin
         store_mem[wr_addr] <= req_item.column_bits;
      end
      if (cmd.rd_en && glyph_ok_ff) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // glyph columns; a glyph beyond the store reads as blank
   logic [6:0] cols_ff [CELL_COLS];

   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         cols_ff[cmd.cap_col] <= glyph_ok_ff ? rd_data_ff : 7'd0;
      end
   end

   // column enables depend on the item and the configuration registers, refreshed every cycle
   logic signed [13:0] clip_right, clip_bottom;
   logic signed [13:0] w_ext, h_ext, px, py;
   logic [7:0]         col_en_in, col_en_ff;

   assign clip_right  = 14'(clip_left_ff) + $signed({2'b00, clip_w_ff});
   assign clip_bottom = 14'(clip_top_ff) + $signed({2'b00, clip_h_ff});
   assign w_ext       = $signed({3'b000, w_sat});
   assign h_ext       = $signed({3'b000, h_sat});

   always_comb begin
      px = '0;
      for (int dx = 0; dx < 8; dx++) begin
         px = 14'(x_ff) + 14'(dx);
         col_en_in[dx] = (4'(dx) < CELL_W[fsel_ff]) && (px >= 14'sd0) && (px < w_ext) &&
                         (!clip_ff || (px >= 14'(clip_left_ff) && px < clip_right));
      end
   end

   always_ff @(posedge clock) begin
      col_en_ff <= col_en_in;
   end

   // row mask
   logic [2:0] sy;
   logic [4:0] src_bits, glyph_bits;
   logic [7:0] row_mask;
   logic       row_ok;

   assign sy = ROW_MAP[fsel_ff][cmd.dy];

   always_comb begin
      for (int c = 0; c < CELL_COLS; c++) begin
         src_bits[c] = cols_ff[c][sy];
      end
   end

   // bold ORs in the column to the right
   assign glyph_bits = (fsel_ff == FONT_BOLD) ? (src_bits | {1'b0, src_bits[4:1]}) : src_bits;

   always_comb begin
      for (int dx = 0; dx < 8; dx++) begin
         row_mask[dx] = col_en_ff[dx] & glyph_bits[COL_MAP[fsel_ff][dx]];
      end
   end

   assign py     = 14'(y_ff) + 14'(cmd.dy);
   assign row_ok = (py >= 14'sd0) && (py < h_ext) &&
                   (!clip_ff || (py >= 14'(clip_top_ff) && py < clip_bottom));

   // pending row, held until it is known whether a later row follows
   logic [9:0] pend_y_ff;
   logic [7:0] pend_mask_ff;

   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_y_ff    <= py[9:0];
         pend_mask_ff <= row_mask;
      end
   end

   // output register
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   logic         out_load;

   assign out_load = cmd.pend_push || cmd.pend_flush;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_item_ff.out_display <= dsel_ff;
         rsp_item_ff.row_y       <= pend_y_ff;
         rsp_item_ff.row_x       <= x_ff;
         rsp_item_ff.pixel_mask  <= pend_mask_ff;
         rsp_item_ff.out_color   <= color_ff;
         rsp_item_ff.last_row    <= cmd.pend_flush;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_item_ff;
   assign status.row_hit  = row_ok && (row_mask != 8'd0);
   assign status.row_end  = cmd.dy == (CELL_H[fsel_ff] - 4'd1);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

// File: rtl/sbgr_controller.sv
// Sequencer: request intake, glyph column fetch, row walk and final flush.
// Uses sbgr_pkg; drives the datapath command struct.
module sbgr_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_draw,
   output logic                    req_ready,
   input  sbgr_pkg::dp_status_type status,
   output sbgr_pkg::ctl_cmd_type   cmd
);
   import sbgr_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_ROW   = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   localparam col_idx_type FETCH_LAST = col_idx_type'(CELL_COLS);

   logic [1:0]  state_ff, state_in;
   col_idx_type cnt_ff, cnt_in;
   dy_type      dy_ff, dy_in;
   logic        pend_valid_ff, pend_valid_in;
   logic        fire, stall;

   assign req_ready = state_ff == ST_IDLE;
   assign fire      = req_valid && req_ready;
   assign stall     = status.row_hit && pend_valid_ff && !status.out_free;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      dy_in         = dy_ff;
      pend_valid_in = pend_valid_ff;
      cmd           = '0;
      cmd.dy        = dy_ff;
      cmd.rd_col    = cnt_ff;
      cmd.cap_col   = cnt_ff - 3'd1;
      unique case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               if (req_draw) begin
                  cmd.start     = 1'b1;
                  cnt_in        = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_FETCH;
               end else begin
                  cmd.store_wr = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            // read column n, capture column n-1 from the registered read
            cmd.rd_en  = cnt_ff < FETCH_LAST;
            cmd.cap_en = cnt_ff != 3'd0;
            if (cnt_ff == FETCH_LAST) begin
               dy_in    = '0;
               state_in = ST_ROW;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_ROW: begin
            if (!stall) begin
               if (status.row_hit) begin
                  cmd.pend_load = 1'b1;
                  cmd.pend_push = pend_valid_ff;
                  pend_valid_in = 1'b1;
               end
               if (status.row_end) begin
                  state_in = ST_FLUSH;
               end else begin
                  dy_in = dy_ff + 4'd1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.pend_flush = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         dy_ff         <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         dy_ff         <= dy_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

endmodule

// File: sim/sbgr_row_checker.sv
// Row checker for the glyph rasterizer: watches the request, row and register channels,
// predicts the pixel-mask rows of every draw request and compares them in order.
// Depends on sbgr_pkg and the channel interfaces in sbgr_intf.sv.
module sbgr_row_checker #(
   parameter int GLYPH_COUNT = 95
) (
   input  logic clock,
   input  logic reset,
   sbgr_req_if  req_mon,
   sbgr_rsp_if  rsp_mon,
   sbgr_csr_if  csr_mon,
   output int   error_count,
   output int   rows_pending
);
   import sbgr_pkg::*;

   localparam logic [2:0] FONT_TINY      = 3'd1;
   localparam logic [2:0] FONT_SMALL     = 3'd2;
   localparam logic [2:0] FONT_CONDENSED = 3'd3;
   localparam logic [2:0] FONT_LARGE     = 3'd4;
   localparam logic [2:0] FONT_XLARGE    = 3'd5;
   localparam logic [2:0] FONT_GLOBAL    = 3'd6;

   logic [6:0]         font_copy [GLYPH_COUNT*CELL_COLS];
   logic [10:0]        disp_w;
   logic [10:0]        disp_h;
   logic signed [11:0] clip_l;
   logic signed [11:0] clip_t;
   logic [11:0]        clip_wd;
   logic [11:0]        clip_ht;

   rsp_item_type expected_rows [$];
   int mismatches = 0;

   function automatic int cell_cols(input logic [2:0] font);
      case (font)
         FONT_TINY:                 return 3;
         FONT_SMALL, FONT_CONDENSED: return 4;
         FONT_LARGE:                return 6;
         FONT_XLARGE:               return 7;
         FONT_GLOBAL:               return 8;
         default:                   return 5;
      endcase
   endfunction

   function automatic int cell_lines(input logic [2:0] font);
      case (font)
         FONT_TINY, FONT_SMALL: return 5;
         FONT_LARGE:            return 9;
         FONT_XLARGE:           return 10;
         FONT_GLOBAL:           return 11;
         default:               return 7;
      endcase
   endfunction

   function automatic void rasterize_glyph(input req_item_type it);
      rsp_item_type rows [$];
      rsp_item_type row;
      logic [7:0]   code;
      logic [6:0]   src [CELL_COLS];
      logic [7:0]   mask;
      logic         lit;
      int gidx, cols, lines, lim_w, lim_h, ox, oy, px, py, sx, sy, cx0, cy0, c, d;
      code = it.char_code;
      if (code < CODE_FIRST || code > CODE_LAST)
         code = CODE_SUBST;
      gidx = int'(code - CODE_FIRST);
      for (c = 0; c < CELL_COLS; c++)
         src[c] = (gidx < GLYPH_COUNT) ? font_copy[gidx*CELL_COLS + c] : 7'd0;
      cols  = cell_cols(it.font_sel);
      lines = cell_lines(it.font_sel);
      lim_w = (disp_w > 1024) ? 1024 : int'(disp_w);
      lim_h = (disp_h > 1024) ? 1024 : int'(disp_h);
      ox  = $signed(it.pos_x);
      oy  = $signed(it.pos_y);
      cx0 = $signed(clip_l);
      cy0 = $signed(clip_t);
      for (d = 0; d < lines; d++) begin
         sy = (d*6 + (lines - 1)/2) / (lines - 1);
         if (sy > 6) sy = 6;
         py = oy + d;
         if (py < 0 || py >= lim_h) continue;
         if (it.clip_enable && (py < cy0 || py >= cy0 + int'(clip_ht))) continue;
         mask = '0;
         for (c = 0; c < cols; c++) begin
            sx = (c*4 + (cols - 1)/2) / (cols - 1);
            if (sx > 4) sx = 4;
            px = ox + c;
            if (px < 0 || px >= lim_w) continue;
            if (it.clip_enable && (px < cx0 || px >= cx0 + int'(clip_wd))) continue;
            lit = src[sx][sy];
            // bold smears each column into its left neighbor
            if (it.font_sel == FONT_BOLD && sx + 1 < CELL_COLS)
               lit = lit | src[sx+1][sy];
            if (lit) mask[c] = 1'b1;
         end
         if (mask == '0) continue;
         row.out_display = it.display_sel;
         row.row_y       = py[9:0];
         row.row_x       = it.pos_x;
         row.pixel_mask  = mask;
         row.out_color   = it.ink_color;
         row.last_row    = 1'b0;
         rows.push_back(row);
      end
      if (rows.size() > 0)
         rows[rows.size()-1].last_row = 1'b1;
      foreach (rows[i])
         expected_rows.push_back(rows[i]);
   endfunction

   function automatic void compare_field(input string field, input longint want,
                                         input longint got);
      if (want != got) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      req_item_type it;
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         disp_w  = 11'd320;
         disp_h  = 11'd240;
         clip_l  = '0;
         clip_t  = '0;
         clip_wd = '0;
         clip_ht = '0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_DISPLAY_WIDTH:  disp_w  = csr_mon.data[10:0];
               REG_DISPLAY_HEIGHT: disp_h  = csr_mon.data[10:0];
               REG_CLIP_LEFT:      clip_l  = csr_mon.data;
               REG_CLIP_TOP:       clip_t  = csr_mon.data;
               REG_CLIP_WIDTH:     clip_wd = csr_mon.data;
               REG_CLIP_HEIGHT:    clip_ht = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            it.mode        = req_mon.mode;
            it.char_code   = req_mon.char_code;
            it.font_column = req_mon.font_column;
            it.column_bits = req_mon.column_bits;
            it.pos_x       = req_mon.pos_x;
            it.pos_y       = req_mon.pos_y;
            it.font_sel    = req_mon.font_sel;
            it.clip_enable = req_mon.clip_enable;
            it.ink_color   = req_mon.ink_color;
            it.display_sel = req_mon.display_sel;
            if (it.mode == MODE_DRAW) begin
               rasterize_glyph(it);
            end else if (it.char_code >= CODE_FIRST &&
                         int'(it.char_code - CODE_FIRST) < GLYPH_COUNT &&
                         it.font_column < CELL_COLS) begin
               font_copy[int'(it.char_code - CODE_FIRST)*CELL_COLS + it.font_column] =
                  it.column_bits;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.out_display = rsp_mon.out_display;
            got.row_y       = rsp_mon.row_y;
            got.row_x       = rsp_mon.row_x;
            got.pixel_mask  = rsp_mon.pixel_mask;
            got.out_color   = rsp_mon.out_color;
            got.last_row    = rsp_mon.last_row;
            if (expected_rows.size() == 0) begin
               $display("%0t: row y=%0d x=%0d mask=0x%0h with no request waiting for it",
                        $time, got.row_y, got.row_x, got.pixel_mask);
               mismatches++;
            end else begin
               want = expected_rows.pop_front();
               compare_field("out_display", want.out_display, got.out_display);
               compare_field("row_y", want.row_y, got.row_y);
               compare_field("row_x", want.row_x, got.row_x);
               compare_field("pixel_mask", want.pixel_mask, got.pixel_mask);
               compare_field("out_color", want.out_color, got.out_color);
               compare_field("last_row", want.last_row, got.last_row);
            end
         end
      end
      error_count  <= mismatches;
      rows_pending <= expected_rows.size();
   end

endmodule

// File: sim/tb_scaled_bitmap_glyph_rasterizer_unit.sv
// Testbench top for the glyph rasterizer: clock, reset, font loading, draw requests,
// register phases and random back-pressure; the verdict comes from sbgr_row_checker.
// Depends on sbgr_pkg, sbgr_intf.sv, sbgr_row_checker and the rasterizer RTL.
module tb_scaled_bitmap_glyph_rasterizer_unit;
   import sbgr_pkg::*;

   localparam int GLYPH_COUNT   = 95;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 9;
   localparam int LOADED_COUNT  = 6;

   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   localparam logic [7:0] GLYPH_BLANK  = " ";
   localparam logic [7:0] GLYPH_SOLID  = "#";
   localparam logic [7:0] GLYPH_BANG   = "!";
   localparam logic [7:0] GLYPH_LETTER = "A";

   // these glyphs are filled at the start, so draws stay within them
   localparam logic [7:0] LOADED_GLYPHS [LOADED_COUNT] = '{
      GLYPH_BLANK, GLYPH_SOLID, GLYPH_BANG, CODE_SUBST, GLYPH_LETTER, CODE_LAST
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   rows_pending;
   int   cycles = 0;
   int   view_w = 320;
   int   view_h = 240;

   sbgr_req_if req_bus ();
   sbgr_rsp_if rsp_bus ();
   sbgr_csr_if csr_bus ();

   scaled_bitmap_glyph_rasterizer_unit #(.GLYPH_COUNT(GLYPH_COUNT)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   sbgr_row_checker #(.GLYPH_COUNT(GLYPH_COUNT)) row_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_mon      (csr_bus),
      .error_count  (error_count),
      .rows_pending (rows_pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_scaled_bitmap_glyph_rasterizer_unit: errors");
         $finish;
      end
   end

   function automatic req_item_type load_item(input logic [7:0] code,
                                              input logic [2:0] column,
                                              input logic [6:0] bits);
      req_item_type it;
      it.mode        = MODE_LOAD;
      it.char_code   = code;
      it.font_column = column;
      it.column_bits = bits;
      it.pos_x       = 12'($urandom);
      it.pos_y       = 12'($urandom);
      it.font_sel    = 3'($urandom);
      it.clip_enable = 1'($urandom);
      it.ink_color   = 16'($urandom);
      it.display_sel = 1'($urandom);
      return it;
   endfunction

   function automatic req_item_type draw_item(input logic [7:0] code,
                                              input logic signed [11:0] x,
                                              input logic signed [11:0] y,
                                              input logic [2:0] font,
                                              input logic clip);
      req_item_type it;
      it.mode        = MODE_DRAW;
      it.char_code   = code;
      it.font_column = 3'($urandom);
      it.column_bits = 7'($urandom);
      it.pos_x       = x;
      it.pos_y       = y;
      it.font_sel    = font;
      it.clip_enable = clip;
      it.ink_color   = 16'($urandom);
      it.display_sel = 1'($urandom);
      return it;
   endfunction

   function automatic logic [7:0] loaded_code();
      return LOADED_GLYPHS[$urandom_range(0, LOADED_COUNT - 1)];
   endfunction

   // a loaded glyph mostly, now and then an unprintable code
   function automatic logic [7:0] draw_code();
      if ($urandom_range(0, 6) != 0)
         return loaded_code();
      if ($urandom_range(0, 1) == 0)
         return 8'($urandom_range(0, 31));
      return 8'($urandom_range(127, 255));
   endfunction

   // mostly near the visible area, now and then anywhere in the 12-bit range
   function automatic logic signed [11:0] rand_coord(input int extent);
      if ($urandom_range(0, 4) == 0)
         return 12'($urandom_range(0, 4095));
      return 12'($urandom_range(0, extent + 12) - 10);
   endfunction

   task automatic send_request(input req_item_type it);
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= it.mode;
      req_bus.char_code   <= it.char_code;
      req_bus.font_column <= it.font_column;
      req_bus.column_bits <= it.column_bits;
      req_bus.pos_x       <= it.pos_x;
      req_bus.pos_y       <= it.pos_y;
      req_bus.font_sel    <= it.font_sel;
      req_bus.clip_enable <= it.clip_enable;
      req_bus.ink_color   <= it.ink_color;
      req_bus.display_sel <= it.display_sel;
      do @(negedge clock); while (req_bus.ready !== 1'b1);
      @(posedge clock);
   endtask

   task automatic pause_sender();
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (pick < 55)      gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else                gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_rows();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (rows_pending != 0);
      // a draw with no visible pixel may still be walking its rows
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input int value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= 12'(value);
      do @(negedge clock); while (csr_bus.ready !== 1'b1);
      @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic apply_settings(input int w, input int h, input int cl, input int ct,
                                 input int cw, input int ch);
      write_reg(REG_DISPLAY_WIDTH, w);
      write_reg(REG_DISPLAY_HEIGHT, h);
      write_reg(REG_CLIP_LEFT, cl);
      write_reg(REG_CLIP_TOP, ct);
      write_reg(REG_CLIP_WIDTH, cw);
      write_reg(REG_CLIP_HEIGHT, ch);
      view_w = ((w & 'h7FF) > 1024) ? 1024 : (w & 'h7FF);
      view_h = ((h & 'h7FF) > 1024) ? 1024 : (h & 'h7FF);
   endtask

   // output side: runs of ready, short stalls mostly, a long one now and then
   initial begin
      int high_len;
      int low_len;
      rsp_bus.ready = 1'b0;
      forever begin
         high_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
         low_len  = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 3);
         @(posedge clock);
         rsp_bus.ready <= 1'b1;
         repeat (high_len) @(posedge clock);
         rsp_bus.ready <= 1'b0;
         repeat (low_len - 1) @(posedge clock);
      end
   end

   initial begin
      req_item_type it;
      logic [7:0]   code;
      logic [2:0]   column;
      int phase, counted, g, c, w, h;
      bit held_once;

      req_bus.valid       = 1'b0;
      req_bus.mode        = MODE_LOAD;
      req_bus.char_code   = '0;
      req_bus.font_column = '0;
      req_bus.column_bits = '0;
      req_bus.pos_x       = '0;
      req_bus.pos_y       = '0;
      req_bus.font_sel    = '0;
      req_bus.clip_enable = 1'b0;
      req_bus.ink_color   = '0;
      req_bus.display_sel = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.data        = '0;
      held_once           = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every glyph that is drawn later
      for (g = 0; g < LOADED_COUNT; g++) begin
         for (c = 0; c < CELL_COLS; c++) begin
            code = LOADED_GLYPHS[g];
            if (code == GLYPH_BLANK)      it = load_item(code, 3'(c), 7'h00);
            else if (code == GLYPH_SOLID) it = load_item(code, 3'(c), 7'h7F);
            else                          it = load_item(code, 3'(c), 7'($urandom));
            send_request(it);
         end
      end
      if ($urandom_range(0, 1)) pause_sender();

      // loads that must be dropped; a stored blank column 5 would overwrite
      // the first column of the bang glyph
      send_request(load_item(8'h1F, 3'd0, 7'h7F));
      pause_sender();
      send_request(load_item(8'h7F, 3'd0, 7'h7F));
      pause_sender();
      send_request(load_item(8'hFF, 3'd4, 7'h7F));
      pause_sender();
      send_request(load_item(GLYPH_BLANK, 3'd5, 7'h7F));
      pause_sender();
      send_request(load_item(CODE_LAST, 3'd7, 7'h7F));
      pause_sender();
      send_request(draw_item(GLYPH_BANG, 12'sd30, 12'sd30, 3'($urandom), 1'b0));
      pause_sender();

      // solid glyph through every font size
      for (c = 0; c < 8; c++) begin
         send_request(draw_item(GLYPH_SOLID, 12'sd10, 12'sd20, 3'(c), 1'b0));
         pause_sender();
      end

      // unprintable codes come out as the substitute glyph
      send_request(draw_item(8'h00, 12'sd40, 12'sd40, 3'($urandom), 1'b0));
      pause_sender();
      send_request(draw_item(8'h1F, 12'sd40, 12'sd40, 3'($urandom), 1'b0));
      pause_sender();
      send_request(draw_item(8'h7F, 12'sd40, 12'sd40, 3'($urandom), 1'b0));
      pause_sender();
      send_request(draw_item(8'hFF, 12'sd40, 12'sd40, 3'($urandom), 1'b0));
      pause_sender();

      // blank glyph, edges of the display, far corners, empty clip window
      send_request(draw_item(GLYPH_BLANK, 12'sd50, 12'sd50, 3'($urandom), 1'b0));
      pause_sender();
      send_request(draw_item(GLYPH_SOLID, 12'sd60, -12'sd3, 3'($urandom), 1'b0));
      pause_sender();
      send_request(draw_item(GLYPH_SOLID, 12'sd60, 12'sd236, 3'($urandom), 1'b0));
      pause_sender();
      send_request(draw_item(GLYPH_SOLID, -12'sd2, 12'sd70, 3'($urandom), 1'b0));
      pause_sender();
      send_request(draw_item(GLYPH_SOLID, 12'sd315, 12'sd70, 3'($urandom), 1'b0));
      pause_sender();
      send_request(draw_item(GLYPH_SOLID, 12'sh800, 12'sh800, 3'($urandom), 1'b0));
      pause_sender();
      send_request(draw_item(GLYPH_SOLID, 12'sd2047, 12'sd2047, 3'($urandom), 1'b0));
      pause_sender();
      send_request(draw_item(GLYPH_SOLID, 12'sd20, 12'sd20, 3'($urandom), 1'b1));

      for (phase = 0; phase < PHASES; phase++) begin
         drain_rows();
         case (phase)
            0: apply_settings(320, 240, 16, 8, 200, 150);
            1: begin
               apply_settings(2047, 1024, -2048, -2048, 4095, 4095);
               write_reg(REG_SPARE_LO, $urandom_range(0, 4095));
               write_reg(REG_SPARE_HI, $urandom_range(0, 4095));
            end
            2: apply_settings(1, 1, 0, 0, 1, 1);
            3: apply_settings(0, 7, 2047, 2047, 0, 0);
            4: apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 4095), $urandom_range(0, 4095));
            default: begin
               w = $urandom_range(8, 400);
               h = $urandom_range(8, 300);
               apply_settings(w, h, $urandom_range(0, w) - 8, $urandom_range(0, h) - 8,
                              $urandom_range(0, w), $urandom_range(0, h));
            end
         endcase
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 3) begin
               code   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                    : loaded_code();
               column = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(0, 4));
               it = load_item(code, column, 7'($urandom));
            end else begin
               it = draw_item(draw_code(), rand_coord(view_w), rand_coord(view_h),
                              3'($urandom), 1'($urandom_range(0, 3) == 0));
            end
            counted++;
            send_request(it);
            pause_sender();
            if ((!held_once && counted >= PHASE_ITEMS/2) || $urandom_range(0, 29) == 0) begin
               held_once = 1'b1;
               drain_rows();
            end
         end
      end

      drain_rows();
      if (error_count == 0)
         $display("tb_scaled_bitmap_glyph_rasterizer_unit: clean");
      else
         $display("tb_scaled_bitmap_glyph_rasterizer_unit: errors");
      $finish;
   end

endmodule
